>>> design/closest_point_on_triangle_assert.svh
// ---------------------------------------------------------------------------
// closest point on triangle: assertion macros
// shared property forms for the pipeline checks
// ---------------------------------------------------------------------------
`ifndef CLOSEST_POINT_ON_TRIANGLE_ASSERT_SVH
`define CLOSEST_POINT_ON_TRIANGLE_ASSERT_SVH

// same-cycle implication
`define CPT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/cpt_pkg.sv
// ---------------------------------------------------------------------------
// cpt_pkg
// types, widths and codes of the closest point on triangle pipeline
// ---------------------------------------------------------------------------
package cpt_pkg;

  localparam int COORD_W  = 32;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int DOT_W    = PROD_W + 2;
  localparam int HALF_W   = DOT_W / 2;
  localparam int PART_W   = 2 * (HALF_W + 1);
  localparam int AREA_P_W = 2 * DOT_W;
  localparam int AREA_W   = AREA_P_W + 1;
  localparam int SUM_W    = AREA_W + 2;
  localparam int EDGE_W   = DOT_W + 2;
  localparam int REM_W    = SUM_W + 2;
  localparam int QUO_BITS = 30;
  localparam int WEIGHT_W = QUO_BITS + 1;
  localparam int TERM_W   = 66;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << QUO_BITS;
  localparam logic [WEIGHT_W-1:0] WEIGHT_HALF = WEIGHT_W'(1) << (QUO_BITS - 1);

  localparam logic [2:0] RGN_VERT_A  = 3'd0;
  localparam logic [2:0] RGN_VERT_B  = 3'd1;
  localparam logic [2:0] RGN_EDGE_AB = 3'd2;
  localparam logic [2:0] RGN_VERT_C  = 3'd3;
  localparam logic [2:0] RGN_EDGE_AC = 3'd4;
  localparam logic [2:0] RGN_EDGE_BC = 3'd5;
  localparam logic [2:0] RGN_FACE    = 3'd6;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] az;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] bz;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
  } in_t;

  typedef struct packed {
    logic [2:0]                region;
    logic [WEIGHT_W-1:0]       weight_u;
    logic [WEIGHT_W-1:0]       weight_v;
    logic [WEIGHT_W-1:0]       weight_w;
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qy;
    logic signed [COORD_W-1:0] qz;
  } out_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] a;
    logic [2:0][DIFF_W-1:0]  ab;
    logic [2:0][DIFF_W-1:0]  ac;
  } geom_t;

  typedef struct packed {
    logic [5:0][DOT_W-1:0] d;
    geom_t                 g;
  } dots_t;

  typedef struct packed {
    logic [2:0]              region;
    logic signed [REM_W-1:0] num0;
    logic signed [REM_W-1:0] den0;
    logic signed [REM_W-1:0] num1;
    logic signed [REM_W-1:0] den1;
    geom_t                   g;
  } div_in_t;

  typedef struct packed {
    logic [2:0]          region;
    logic [WEIGHT_W-1:0] t0;
    logic [WEIGHT_W-1:0] t1;
    geom_t               g;
  } div_out_t;

  function automatic logic signed [DIFF_W-1:0] diff(input logic signed [COORD_W-1:0] x,
                                                     input logic signed [COORD_W-1:0] y);
    return DIFF_W'(x) - DIFF_W'(y);
  endfunction

endpackage

>>> design/closest_point_on_triangle.sv
// ---------------------------------------------------------------------------
// closest_point_on_triangle
// closest point on a triangle to a query point, with barycentric weights
// ---------------------------------------------------------------------------
// A request carries the query point and the three vertices (in_req, signed
// Q16.16) and is taken at a rising edge where start is high and busy is low.
// busy stays low: the pipeline takes one request in every cycle.
// Each request gives one result on out_res, marked by out_valid for a single
// cycle; results leave in request order. The result holds the region code,
// weights u, v, w (unsigned Q1.30) and the closest point (signed Q16.16,
// saturated).
// The pipeline stages are three for the dot products, five for the
// area products and region select, thirty-one for the two-lane divider (one
// quotient bit per stage after the first) and three for weights and the point.
// The receiver cannot stall, so nothing holds a result back.
// Reset clears every valid bit; requests in flight are dropped.
// ---------------------------------------------------------------------------
module closest_point_on_triangle (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  cpt_pkg::in_t  in_req,
  output logic          out_valid,
  output cpt_pkg::out_t out_res
);

  logic              in_vld;
  logic              dots_vld;
  cpt_pkg::dots_t    dots;
  logic              div_vld;
  cpt_pkg::div_in_t  div_in;
  logic              q_vld;
  cpt_pkg::div_out_t q_out;

  assign busy   = 1'b0;
  assign in_vld = start && !busy;

  cpt_dots u_dots (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld),
    .in_req   (in_req),
    .dots_vld (dots_vld),
    .dots     (dots)
  );

  cpt_areas u_areas (
    .clk      (clk),
    .rst_n    (rst_n),
    .dots_vld (dots_vld),
    .dots     (dots),
    .div_vld  (div_vld),
    .div_in   (div_in)
  );

  cpt_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_vld (div_vld),
    .div_in  (div_in),
    .q_vld   (q_vld),
    .q_out   (q_out)
  );

  cpt_point u_point (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_vld     (q_vld),
    .q_out     (q_out),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

>>> design/cpt_dots.sv
// ---------------------------------------------------------------------------
// cpt_dots
// input register, edge products and the six dot products
// ---------------------------------------------------------------------------
module cpt_dots (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  input  cpt_pkg::in_t   in_req,
  output logic           dots_vld,
  output cpt_pkg::dots_t dots
);

  localparam int DW = cpt_pkg::DOT_W;

  logic v1_r, v2_r, v3_r;
  cpt_pkg::in_t in_r;
  cpt_pkg::geom_t g1, g2_r, g3_r;

  logic signed [cpt_pkg::COORD_W-1:0] pv [3];
  logic signed [cpt_pkg::COORD_W-1:0] av [3];
  logic signed [cpt_pkg::COORD_W-1:0] bv [3];
  logic signed [cpt_pkg::COORD_W-1:0] cv [3];
  logic signed [cpt_pkg::DIFF_W-1:0]  ab [3];
  logic signed [cpt_pkg::DIFF_W-1:0]  ac [3];
  logic signed [cpt_pkg::DIFF_W-1:0]  rel [3][3];

  logic signed [cpt_pkg::PROD_W-1:0] prod_nxt [6][3];
  logic signed [cpt_pkg::PROD_W-1:0] prod_r [6][3];
  logic signed [DW-1:0]              dot_nxt [6];
  logic signed [DW-1:0]              dot_r [6];

  always_comb begin
    pv = '{in_r.px, in_r.py, in_r.pz};
    av = '{in_r.ax, in_r.ay, in_r.az};
    bv = '{in_r.bx, in_r.by, in_r.bz};
    cv = '{in_r.cx, in_r.cy, in_r.cz};
    for (int i = 0; i < 3; i++) begin
      ab[i] = cpt_pkg::diff(bv[i], av[i]);
      ac[i] = cpt_pkg::diff(cv[i], av[i]);
      rel[0][i] = cpt_pkg::diff(pv[i], av[i]);
      rel[1][i] = cpt_pkg::diff(pv[i], bv[i]);
      rel[2][i] = cpt_pkg::diff(pv[i], cv[i]);
      g1.a[i] = av[i];
      g1.ab[i] = ab[i];
      g1.ac[i] = ac[i];
    end
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        prod_nxt[2*j][i] = ab[i] * rel[j][i];
        prod_nxt[2*j+1][i] = ac[i] * rel[j][i];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      dot_nxt[k] = DW'(prod_r[k][0]) + DW'(prod_r[k][1]) + DW'(prod_r[k][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    in_r   <= in_req;
    prod_r <= prod_nxt;
    g2_r   <= g1;
    dot_r  <= dot_nxt;
    g3_r   <= g2_r;
  end

  always_comb begin
    dots_vld = v3_r;
    for (int k = 0; k < 6; k++) begin
      dots.d[k] = dot_r[k];
    end
    dots.g = g3_r;
  end

endmodule

>>> design/cpt_areas.sv
// ---------------------------------------------------------------------------
// cpt_areas
// area products, region tests and divider operand select
// ---------------------------------------------------------------------------
module cpt_areas (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             dots_vld,
  input  cpt_pkg::dots_t   dots,
  output logic             div_vld,
  output cpt_pkg::div_in_t div_in
);

  localparam int HW = cpt_pkg::HALF_W;
  localparam int DW = cpt_pkg::DOT_W;
  localparam int EW = cpt_pkg::EDGE_W;
  localparam int PW = cpt_pkg::AREA_P_W;
  localparam int AW = cpt_pkg::AREA_W;
  localparam int SW = cpt_pkg::SUM_W;
  localparam int RW = cpt_pkg::REM_W;
  localparam int PA [6] = '{0, 2, 4, 0, 2, 4};
  localparam int PB [6] = '{3, 1, 1, 5, 5, 3};

  typedef struct packed {
    logic signed [DW-1:0] n_ab;
    logic signed [DW-1:0] n_ac;
    logic signed [EW-1:0] e43;
    logic signed [EW-1:0] d_ab;
    logic signed [EW-1:0] d_ac;
    logic signed [EW-1:0] d_bc;
  } edge_t;

  typedef struct packed {
    logic vert_a;
    logic vert_b;
    logic side_ab;
    logic vert_c;
    logic side_ac;
    logic side_bc;
  } test_t;

  logic vld1_r, vld2_r, vld3_r, vld4_r, vld5_r;

  logic signed [DW-1:0] d [6];
  logic signed [cpt_pkg::PART_W-1:0] part_nxt [6][4];
  logic signed [cpt_pkg::PART_W-1:0] part_r [6][4];
  logic signed [DW-1:0] d1_r [6];
  logic signed [EW-1:0] e56_1_r;
  edge_t ed1_nxt, ed1_r, ed2_nxt, ed2_r, ed3_r, ed4_r;
  cpt_pkg::geom_t g1_r, g2_r, g3_r, g4_r;

  logic signed [PW-1:0] prod_nxt [6];
  logic signed [PW-1:0] prod_r [6];
  test_t tst_nxt, tst2_r, tst3_r, tst4_r;

  logic signed [AW-1:0] va_nxt, vb_nxt, vc_nxt, va_r, vb_r, vc_r;
  logic signed [AW-1:0] vb4_r, vc4_r;
  logic signed [SW-1:0] s_nxt, s_r;
  logic va_le_r, vb_le_r, vc_le_r;

  cpt_pkg::div_in_t sel_nxt, sel_r;

  // stage 1: partial products of the area terms
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      d[k] = $signed(dots.d[k]);
    end
    for (int n = 0; n < 6; n++) begin
      part_nxt[n][0] = $signed(d[PA[n]][DW-1:HW]) * $signed(d[PB[n]][DW-1:HW]);
      part_nxt[n][1] = $signed(d[PA[n]][DW-1:HW]) * $signed({1'b0, d[PB[n]][HW-1:0]});
      part_nxt[n][2] = $signed({1'b0, d[PA[n]][HW-1:0]}) * $signed(d[PB[n]][DW-1:HW]);
      part_nxt[n][3] = $signed({1'b0, d[PA[n]][HW-1:0]}) *
                       $signed({1'b0, d[PB[n]][HW-1:0]});
    end
    ed1_nxt.n_ab = d[0];
    ed1_nxt.n_ac = d[1];
    ed1_nxt.e43  = EW'(d[3]) - EW'(d[2]);
    ed1_nxt.d_ab = EW'(d[0]) - EW'(d[2]);
    ed1_nxt.d_ac = EW'(d[1]) - EW'(d[5]);
    ed1_nxt.d_bc = '0;
  end

  // stage 2: full area products and the dot tests
  always_comb begin
    for (int n = 0; n < 6; n++) begin
      prod_nxt[n] = (PW'(part_r[n][0]) <<< (2 * HW)) +
                    ((PW'(part_r[n][1]) + PW'(part_r[n][2])) <<< HW) +
                    PW'(part_r[n][3]);
    end
    ed2_nxt = ed1_r;
    ed2_nxt.d_bc = ed1_r.e43 + e56_1_r;
    tst_nxt.vert_a  = (d1_r[0] <= 0) && (d1_r[1] <= 0);
    tst_nxt.vert_b  = (d1_r[2] >= 0) && (d1_r[2] >= d1_r[3]);
    tst_nxt.side_ab = (d1_r[0] >= 0) && (d1_r[2] <= 0);
    tst_nxt.vert_c  = (d1_r[5] >= 0) && (d1_r[5] >= d1_r[4]);
    tst_nxt.side_ac = (d1_r[1] >= 0) && (d1_r[5] <= 0);
    tst_nxt.side_bc = (ed1_r.e43 >= 0) && (e56_1_r >= 0);
  end

  // stage 3: signed areas, stage 4: area sum
  always_comb begin
    vc_nxt = AW'(prod_r[0]) - AW'(prod_r[1]);
    vb_nxt = AW'(prod_r[2]) - AW'(prod_r[3]);
    va_nxt = AW'(prod_r[4]) - AW'(prod_r[5]);
    s_nxt  = SW'(va_r) + SW'(vb_r) + SW'(vc_r);
  end

  // stage 5: region select
  always_comb begin
    sel_nxt        = '0;
    sel_nxt.g      = g4_r;
    sel_nxt.region = cpt_pkg::RGN_VERT_A;
    if (tst4_r.vert_a) begin
      sel_nxt.region = cpt_pkg::RGN_VERT_A;
    end else if (tst4_r.vert_b) begin
      sel_nxt.region = cpt_pkg::RGN_VERT_B;
    end else if (vc_le_r && tst4_r.side_ab) begin
      sel_nxt.region = cpt_pkg::RGN_EDGE_AB;
      sel_nxt.num0   = RW'(ed4_r.n_ab);
      sel_nxt.den0   = RW'(ed4_r.d_ab);
    end else if (tst4_r.vert_c) begin
      sel_nxt.region = cpt_pkg::RGN_VERT_C;
    end else if (vb_le_r && tst4_r.side_ac) begin
      sel_nxt.region = cpt_pkg::RGN_EDGE_AC;
      sel_nxt.num0   = RW'(ed4_r.n_ac);
      sel_nxt.den0   = RW'(ed4_r.d_ac);
    end else if (va_le_r && tst4_r.side_bc) begin
      sel_nxt.region = cpt_pkg::RGN_EDGE_BC;
      sel_nxt.num0   = RW'(ed4_r.e43);
      sel_nxt.den0   = RW'(ed4_r.d_bc);
    end else if (s_r <= 0) begin
      sel_nxt.region = cpt_pkg::RGN_VERT_A;
    end else begin
      sel_nxt.region = cpt_pkg::RGN_FACE;
      sel_nxt.num0   = RW'(vb4_r);
      sel_nxt.den0   = RW'(s_r);
      sel_nxt.num1   = RW'(vc4_r);
      sel_nxt.den1   = RW'(s_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
    end else begin
      vld1_r <= dots_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
    end
  end

  always_ff @(posedge clk) begin
    part_r  <= part_nxt;
    d1_r    <= d;
    e56_1_r <= EW'(d[4]) - EW'(d[5]);
    ed1_r   <= ed1_nxt;
    g1_r    <= dots.g;

    prod_r  <= prod_nxt;
    tst2_r  <= tst_nxt;
    ed2_r   <= ed2_nxt;
    g2_r    <= g1_r;

    va_r    <= va_nxt;
    vb_r    <= vb_nxt;
    vc_r    <= vc_nxt;
    tst3_r  <= tst2_r;
    ed3_r   <= ed2_r;
    g3_r    <= g2_r;

    s_r     <= s_nxt;
    vb4_r   <= vb_r;
    vc4_r   <= vc_r;
    va_le_r <= (va_r <= 0);
    vb_le_r <= (vb_r <= 0);
    vc_le_r <= (vc_r <= 0);
    tst4_r  <= tst3_r;
    ed4_r   <= ed3_r;
    g4_r    <= g3_r;

    sel_r   <= sel_nxt;
  end

  assign div_vld = vld5_r;
  assign div_in  = sel_r;

endmodule

>>> design/cpt_div.sv
// ---------------------------------------------------------------------------
// cpt_div
// two-lane pipelined restoring divider, one quotient bit per stage
// ---------------------------------------------------------------------------
`include "closest_point_on_triangle_assert.svh"

module cpt_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              div_vld,
  input  cpt_pkg::div_in_t  div_in,
  output logic              q_vld,
  output cpt_pkg::div_out_t q_out
);

  localparam int RW = cpt_pkg::REM_W;
  localparam int QB = cpt_pkg::QUO_BITS;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [RW-1:0] den;
    logic [QB-1:0] q;
    logic          zero;
    logic          one;
  } lane_t;

  typedef struct packed {
    lane_t [1:0]    ln;
    logic [2:0]     region;
    cpt_pkg::geom_t g;
  } stg_t;

  logic vld_r [QB+1];
  stg_t stg_r [QB+1];
  stg_t stg0_nxt;

  always_comb begin
    stg0_nxt.region      = div_in.region;
    stg0_nxt.g           = div_in.g;
    stg0_nxt.ln[0].rem   = div_in.num0;
    stg0_nxt.ln[0].den   = div_in.den0;
    stg0_nxt.ln[0].q     = '0;
    stg0_nxt.ln[0].zero  = (div_in.den0 <= 0) || (div_in.num0 <= 0);
    stg0_nxt.ln[0].one   = (div_in.num0 >= div_in.den0);
    stg0_nxt.ln[1].rem   = div_in.num1;
    stg0_nxt.ln[1].den   = div_in.den1;
    stg0_nxt.ln[1].q     = '0;
    stg0_nxt.ln[1].zero  = (div_in.den1 <= 0) || (div_in.num1 <= 0);
    stg0_nxt.ln[1].one   = (div_in.num1 >= div_in.den1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    stg_r[0] <= stg0_nxt;
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    stg_t          nx;
    logic [RW-1:0] sh [2];
    logic          ge [2];

    always_comb begin
      nx = stg_r[k-1];
      for (int l = 0; l < 2; l++) begin
        sh[l] = {stg_r[k-1].ln[l].rem[RW-2:0], 1'b0};
        ge[l] = (sh[l] >= stg_r[k-1].ln[l].den);
        nx.ln[l].rem = ge[l] ? (sh[l] - stg_r[k-1].ln[l].den) : sh[l];
        nx.ln[l].q   = {stg_r[k-1].ln[l].q[QB-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      stg_r[k] <= nx;
    end
  end

  always_comb begin
    q_vld        = vld_r[QB];
    q_out.region = stg_r[QB].region;
    q_out.g      = stg_r[QB].g;
    q_out.t0     = stg_r[QB].ln[0].zero ? '0 :
                   stg_r[QB].ln[0].one ? cpt_pkg::WEIGHT_ONE :
                   cpt_pkg::WEIGHT_W'(stg_r[QB].ln[0].q);
    q_out.t1     = stg_r[QB].ln[1].zero ? '0 :
                   stg_r[QB].ln[1].one ? cpt_pkg::WEIGHT_ONE :
                   cpt_pkg::WEIGHT_W'(stg_r[QB].ln[1].q);
  end

  `CPT_ASSERT_IMPL(a_rem_below_den,
    vld_r[QB] && !stg_r[QB].ln[0].zero && !stg_r[QB].ln[0].one,
    stg_r[QB].ln[0].rem < stg_r[QB].ln[0].den, "divider remainder not below divisor")

endmodule

>>> design/cpt_point.sv
// ---------------------------------------------------------------------------
// cpt_point
// final weights and closest point with rounding and saturation
// ---------------------------------------------------------------------------
`include "closest_point_on_triangle_assert.svh"

module cpt_point (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_vld,
  input  cpt_pkg::div_out_t q_out,
  output logic              out_valid,
  output cpt_pkg::out_t     out_res
);

  localparam int WW = cpt_pkg::WEIGHT_W;
  localparam int TW = cpt_pkg::TERM_W;
  localparam int FB = cpt_pkg::QUO_BITS;
  localparam int CW = cpt_pkg::COORD_W;

  logic v1_r, v2_r, v3_r;
  logic [2:0] reg1_r, reg2_r;
  logic [WW-1:0] u_nxt, v_nxt, w_nxt, u1_r, v1w_r, w1_r, u2_r, v2w_r, w2_r;
  logic [WW:0] vw_sum;
  cpt_pkg::geom_t g1_r;

  logic signed [TW-1:0] m1_nxt [3], m2_nxt [3], m1_r [3], m2_r [3];
  logic signed [CW-1:0] a2_r [3];
  logic signed [TW-1:0] t [3];
  logic signed [TW-FB-1:0] rr [3];
  logic signed [CW-1:0] q_nxt [3];
  cpt_pkg::out_t out_r;

  always_comb begin
    u_nxt  = '0;
    v_nxt  = '0;
    w_nxt  = '0;
    vw_sum = {1'b0, q_out.t0} + {1'b0, q_out.t1};
    case (q_out.region)
      cpt_pkg::RGN_VERT_B: begin
        v_nxt = cpt_pkg::WEIGHT_ONE;
      end
      cpt_pkg::RGN_VERT_C: begin
        w_nxt = cpt_pkg::WEIGHT_ONE;
      end
      cpt_pkg::RGN_EDGE_AB: begin
        v_nxt = q_out.t0;
        u_nxt = cpt_pkg::WEIGHT_ONE - q_out.t0;
      end
      cpt_pkg::RGN_EDGE_AC: begin
        w_nxt = q_out.t0;
        u_nxt = cpt_pkg::WEIGHT_ONE - q_out.t0;
      end
      cpt_pkg::RGN_EDGE_BC: begin
        w_nxt = q_out.t0;
        v_nxt = cpt_pkg::WEIGHT_ONE - q_out.t0;
      end
      cpt_pkg::RGN_FACE: begin
        v_nxt = q_out.t0;
        w_nxt = (vw_sum > {1'b0, cpt_pkg::WEIGHT_ONE}) ?
                (cpt_pkg::WEIGHT_ONE - q_out.t0) : q_out.t1;
        u_nxt = cpt_pkg::WEIGHT_ONE - v_nxt - w_nxt;
      end
      default: begin
        u_nxt = cpt_pkg::WEIGHT_ONE;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m1_nxt[i] = $signed(g1_r.ab[i]) * $signed({1'b0, v1w_r});
      m2_nxt[i] = $signed(g1_r.ac[i]) * $signed({1'b0, w1_r});
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t[i]  = (TW'(a2_r[i]) <<< FB) + m1_r[i] + m2_r[i] + TW'(cpt_pkg::WEIGHT_HALF);
      rr[i] = $signed(t[i][TW-1:FB]);
      if (rr[i][TW-FB-1:CW-1] == '0 || rr[i][TW-FB-1:CW-1] == '1) begin
        q_nxt[i] = rr[i][CW-1:0];
      end else if (rr[i][TW-FB-1]) begin
        q_nxt[i] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        q_nxt[i] = {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= q_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    reg1_r <= q_out.region;
    u1_r   <= u_nxt;
    v1w_r  <= v_nxt;
    w1_r   <= w_nxt;
    g1_r   <= q_out.g;

    reg2_r <= reg1_r;
    u2_r   <= u1_r;
    v2w_r  <= v1w_r;
    w2_r   <= w1_r;
    m1_r   <= m1_nxt;
    m2_r   <= m2_nxt;
    for (int i = 0; i < 3; i++) begin
      a2_r[i] <= $signed(g1_r.a[i]);
    end

    out_r.region   <= reg2_r;
    out_r.weight_u <= u2_r;
    out_r.weight_v <= v2w_r;
    out_r.weight_w <= w2_r;
    out_r.qx       <= q_nxt[0];
    out_r.qy       <= q_nxt[1];
    out_r.qz       <= q_nxt[2];
  end

  assign out_valid = v3_r;
  assign out_res   = out_r;

  `CPT_ASSERT_IMPL(a_weight_sum, v3_r,
    32'(out_r.weight_u) + 32'(out_r.weight_v) + 32'(out_r.weight_w) == 32'(cpt_pkg::WEIGHT_ONE),
    "weights do not sum to one")
  `CPT_ASSERT_IMPL(a_vert_a_weight, v3_r && out_r.region == cpt_pkg::RGN_VERT_A,
    out_r.weight_u == cpt_pkg::WEIGHT_ONE, "vertex A result without full weight on A")
  `CPT_ASSERT_NEXT(a_face_follows, q_vld && q_out.region == cpt_pkg::RGN_FACE,
    v1_r && reg1_r == cpt_pkg::RGN_FACE, "face request lost in weight stage")

endmodule
